// ===== src/srtf_pkg.sv =====
// Types and constants shared by the shortest-remaining-time-first scheduler.
// No dependencies; compile before src/srtf_schedule_simulator.sv.
`timescale 1ns / 1ps

package srtf_pkg;

    localparam int TICK_W    = 20;
    localparam int ARRIVAL_W = 16;
    localparam int BURST_W   = 10;
    localparam int JOB_IDX_W = 4;

    typedef struct packed {
        logic [BURST_W-1:0]   burst_length;
        logic [ARRIVAL_W-1:0] arrival_tick;
        logic                 last_job;
    } job_t;

    typedef struct packed {
        logic [JOB_IDX_W-1:0] job_index;
        logic [TICK_W-1:0]    finish_tick;
        logic [TICK_W-1:0]    turnaround;
        logic [TICK_W-1:0]    wait_ticks;
        logic [TICK_W-1:0]    first_run_delay;
        logic                 last_result;
    } result_t;

    // One job's record in the job memory
    typedef struct packed {
        logic [ARRIVAL_W-1:0] arrival;
        logic [BURST_W-1:0]   burst;
        logic [BURST_W-1:0]   remaining;
        logic [TICK_W-1:0]    first_run;
        logic [TICK_W-1:0]    finish;
    } job_rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_UPDATE,
        ST_REPORT,
        ST_DRAIN
    } state_t;

endpackage

// ===== src/srtf_schedule_simulator.sv =====
// Preemptive shortest-remaining-time-first schedule simulator, top level.
// Depends on srtf_pkg (src/srtf_pkg.sv); job records live in a local memory.
`timescale 1ns / 1ps

// Load jobs one per transfer (start while busy is low). The transfer with last_job set, or
// the MAX_JOBS-th transfer, starts the simulation. Each simulated tick runs ST_SCAN: the job
// memory has one read port, so the scan reads one record a cycle over the n loaded jobs, then
// ST_SCAN_END finishes the compare and ST_UPDATE writes the chosen record back. A run of idle
// ticks is skipped in a single such pass. Reporting then keeps busy high through ST_REPORT and
// ST_DRAIN; results follow one a cycle in load order through the read and result registers,
// each marked by strobe for exactly one cycle. busy drops in the cycle that carries the final
// result, so the next job can be taken at the edge that ends it. The receiver must take every
// result as it appears.
module srtf_schedule_simulator #(
    parameter int MAX_JOBS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  srtf_pkg::job_t    job,
    output logic              busy,
    output logic              strobe,
    output srtf_pkg::result_t result
);
    import srtf_pkg::*;

    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    // Job memory: one write port, one registered read port
    job_rec_t mem [MAX_JOBS];
    logic              mem_we;
    logic [IDX_W-1:0]  wr_addr;
    job_rec_t          wr_data;
    logic              mem_re;
    logic [IDX_W-1:0]  rd_addr;
    job_rec_t          rd_data_reg;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  job_count_reg;
    logic [CNT_W-1:0]  done_cnt_reg;
    logic [CNT_W-1:0]  scan_idx_reg;
    logic [TICK_W-1:0] tick_reg;
    logic              cmp_vld_reg;
    logic              rep_vld_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    job_rec_t          best_rec_reg;
    logic [ARRIVAL_W-1:0] min_arr_reg;
    logic              strobe_reg;
    result_t           result_reg;

    logic              scan_last;
    logic              load_full;
    logic              finishing;
    logic [BURST_W-1:0] burst_fix;
    logic              cand_live;
    logic              cand_ready;
    logic [TICK_W-1:0] tat;

    assign scan_last = (scan_idx_reg == job_count_reg - CNT_W'(1));
    assign load_full = (job_count_reg == CNT_W'(MAX_JOBS - 1));
    assign finishing = found_reg && (best_rec_reg.remaining == BURST_W'(1));
    assign burst_fix = (job.burst_length == '0) ? BURST_W'(1) : job.burst_length;

    assign cand_live  = (rd_data_reg.remaining != '0);
    assign cand_ready = cand_live && ({4'b0, rd_data_reg.arrival} <= tick_reg);

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (job.last_job || load_full))
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_last)
                    state_next = ST_SCAN_END;
            end
            ST_SCAN_END:
                state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (finishing && (done_cnt_reg + CNT_W'(1) == job_count_reg))
                    state_next = ST_REPORT;
                else
                    state_next = ST_SCAN;
            end
            ST_REPORT:
            begin
                if (scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Memory control
    always_comb
    begin
        mem_we  = 1'b0;
        wr_addr = job_count_reg[IDX_W-1:0];
        wr_data = best_rec_reg;
        mem_re  = 1'b0;
        rd_addr = scan_idx_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                mem_we            = start;
                wr_data.arrival   = job.arrival_tick;
                wr_data.burst     = burst_fix;
                wr_data.remaining = burst_fix;
                wr_data.first_run = '0;
                wr_data.finish    = '0;
            end
            ST_SCAN, ST_REPORT:
                mem_re = 1'b1;
            ST_UPDATE:
            begin
                mem_we            = found_reg;
                wr_addr           = best_idx_reg;
                wr_data.remaining = best_rec_reg.remaining - BURST_W'(1);
                if (best_rec_reg.remaining == best_rec_reg.burst)
                    wr_data.first_run = tick_reg;
                if (finishing)
                    wr_data.finish = tick_reg + TICK_W'(1);
            end
            ST_SCAN_END, ST_DRAIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        if (mem_re)
            rd_data_reg <= mem[rd_addr];
    end

    // Control and scan bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_count_reg <= '0;
            done_cnt_reg  <= '0;
            scan_idx_reg  <= '0;
            tick_reg      <= '0;
            cmp_vld_reg   <= 1'b0;
            rep_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= (state_reg == ST_SCAN);
            rep_vld_reg <= (state_reg == ST_REPORT);
            strobe_reg  <= rep_vld_reg;

            // advance the read index through the loaded jobs
            if ((state_reg == ST_SCAN || state_reg == ST_REPORT) && !scan_last)
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            else
                scan_idx_reg <= '0;

            if (state_reg == ST_IDLE && start)
            begin
                job_count_reg <= job_count_reg + CNT_W'(1);
                tick_reg      <= '0;
                done_cnt_reg  <= '0;
            end

            if (state_reg == ST_SCAN && scan_idx_reg == '0)
                found_reg <= 1'b0;
            else if (cmp_vld_reg && cand_ready &&
                     (!found_reg || rd_data_reg.remaining < best_rec_reg.remaining))
                found_reg <= 1'b1;

            if (state_reg == ST_UPDATE)
            begin
                if (found_reg)
                begin
                    tick_reg <= tick_reg + TICK_W'(1);
                    if (finishing)
                        done_cnt_reg <= done_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    // nothing has arrived: jump straight to the next arrival
                    tick_reg <= {4'b0, min_arr_reg};
                end
            end

            if (state_reg == ST_DRAIN)
            begin
                job_count_reg <= '0;
                done_cnt_reg  <= '0;
            end
        end
    end

    // Best candidate and earliest pending arrival
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN && scan_idx_reg == '0)
            min_arr_reg <= '1;
        else if (cmp_vld_reg && cand_live && rd_data_reg.arrival < min_arr_reg)
            min_arr_reg <= rd_data_reg.arrival;

        if (cmp_vld_reg && cand_ready &&
            (!found_reg || rd_data_reg.remaining < best_rec_reg.remaining))
        begin
            best_rec_reg <= rd_data_reg;
            best_idx_reg <= rd_idx_reg;
        end

        if (mem_re)
            rd_idx_reg <= scan_idx_reg[IDX_W-1:0];
    end

    // Result formatting
    assign tat = rd_data_reg.finish - {4'b0, rd_data_reg.arrival};

    always_ff @(posedge clk)
    begin
        if (rep_vld_reg)
        begin
            result_reg.job_index       <= JOB_IDX_W'(rd_idx_reg);
            result_reg.finish_tick     <= rd_data_reg.finish;
            result_reg.turnaround      <= tat;
            result_reg.wait_ticks      <= tat - {10'b0, rd_data_reg.burst};
            result_reg.first_run_delay <= rd_data_reg.first_run - {4'b0, rd_data_reg.arrival};
            result_reg.last_result     <= (CNT_W'(rd_idx_reg) + CNT_W'(1) == job_count_reg);
        end
    end

    // Results only appear once the simulation has finished
    a_strobe_phase: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (state_reg == ST_REPORT || state_reg == ST_DRAIN || state_reg == ST_IDLE))
        else $error("result strobe during simulation");

    a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_cnt_reg <= job_count_reg)
        else $error("more jobs finished than loaded");

    a_pick_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && found_reg) |-> (best_rec_reg.remaining != '0))
        else $error("finished job chosen to run");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last_result) |=> !strobe)
        else $error("transfer after final result");

endmodule
